FILE: rtl/lsq_pkg.sv
`timescale 1ns / 1ps
package lsq_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int FRAC_BITS   = 24;

    localparam int SAMPLE_W = 32;
    localparam int GAIN_W   = 32;
    localparam int PROD_W   = SAMPLE_W - 1 + GAIN_W;
    localparam int CODE_W   = 16;
    localparam int TOTAL_W  = 32;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(64'd1 << FRAC_BITS);
    localparam logic [PROD_W-1:0] PROD_ONE   = PROD_W'(64'd1 << (2 * FRAC_BITS));
    localparam logic [CODE_W-1:0] CODE_MAX   = '1;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_LINEAR_GAIN  = 1'b0,
        REG_CLAMP_ENABLE = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NEG_REJ  = 2'd1,
        ST_OVER_REJ = 2'd2,
        ST_HALTED   = 2'd3
    } t_status;

    typedef struct packed {
        logic              neg;
        logic              below;
        logic [PROD_W-1:0] prod;
    } t_prod;

    typedef struct packed {
        logic              below;
        logic              above;
        logic [CODE_W-1:0] code;
    } t_qres;

    function automatic logic [TOTAL_W-1:0] total_of(input logic [COUNT_WIDTH-1:0] c);
        return TOTAL_W'(c);
    endfunction

endpackage

FILE: rtl/lsq_mul.sv
`timescale 1ns / 1ps
module lsq_mul
    import lsq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [GAIN_W-1:0]   i_gain,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_valid,
    input  logic                i_ready,
    output t_prod               o_prod
);

    logic                r_a_valid;
    logic [SAMPLE_W-1:0] r_a_sample;
    logic                r_b_valid;
    t_prod               r_b;
    t_prod               n_b;
    logic                w_ld_a;
    logic                w_ld_b;

    assign w_ld_b  = r_a_valid && (!r_b_valid || i_ready);
    assign o_ready = !r_a_valid || w_ld_b;
    assign w_ld_a  = i_valid && o_ready;

    // a negative sample never reaches the multiplier: only its sign and a zero gain matter
    always_comb begin
        n_b.neg   = r_a_sample[SAMPLE_W-1];
        n_b.below = r_a_sample[SAMPLE_W-1] && (i_gain != '0);
        n_b.prod  = r_a_sample[SAMPLE_W-1] ? '0
                  : PROD_W'(r_a_sample[SAMPLE_W-2:0]) * PROD_W'(i_gain);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (!r_b_valid || i_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_a) begin
            r_a_sample <= i_sample;
        end
        if (w_ld_b) begin
            r_b <= n_b;
        end
    end

    assign o_valid = r_b_valid;
    assign o_prod  = r_b;

endmodule

FILE: rtl/lsq_quant.sv
`timescale 1ns / 1ps
module lsq_quant
    import lsq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_prod i_prod,
    output logic  o_valid,
    input  logic  i_ready,
    output t_qres o_qres
);

    localparam int QSHIFT = 2 * FRAC_BITS - 16;
    localparam logic [63:0] ROUND_HALF = 64'd1 << (2 * FRAC_BITS - 17);

    logic        r_valid;
    t_qres       r_q;
    t_qres       n_q;
    logic [63:0] w_hi;
    logic [31:0] w_lo_scaled;
    logic [63:0] w_acc;
    logic        w_ld;

    assign o_ready = !r_valid || i_ready;
    assign w_ld    = i_valid && o_ready;

    // x*65535 done as (x << 16) - x on the high and low halves of the product
    always_comb begin
        w_hi        = 64'(i_prod.prod >> 16);
        w_lo_scaled = {i_prod.prod[15:0], 16'd0} - {16'd0, i_prod.prod[15:0]};
        w_acc       = (w_hi << 16) - w_hi + ROUND_HALF + 64'(w_lo_scaled[31:16]);

        n_q.below = i_prod.below;
        n_q.above = !i_prod.neg && (i_prod.prod > PROD_ONE);
        if (i_prod.neg) begin
            n_q.code = '0;
        end else if (i_prod.prod >= PROD_ONE) begin
            n_q.code = CODE_MAX;
        end else begin
            n_q.code = CODE_W'(w_acc >> QSHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_q <= n_q;
        end
    end

    assign o_valid = r_valid;
    assign o_qres  = r_q;

endmodule

FILE: rtl/lsq_acct.sv
`timescale 1ns / 1ps
module lsq_acct
    import lsq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clamp_en,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_qres              i_qres,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CODE_W-1:0]  o_code,
    output t_status            o_status,
    output logic [TOTAL_W-1:0] o_quantized_total,
    output logic [TOTAL_W-1:0] o_negative_total,
    output logic [TOTAL_W-1:0] o_overrange_total
);

    logic                   r_valid;
    logic                   r_halted;
    logic                   n_halted;
    logic [COUNT_WIDTH-1:0] r_q_cnt;
    logic [COUNT_WIDTH-1:0] n_q_cnt;
    logic [COUNT_WIDTH-1:0] r_n_cnt;
    logic [COUNT_WIDTH-1:0] n_n_cnt;
    logic [COUNT_WIDTH-1:0] r_o_cnt;
    logic [COUNT_WIDTH-1:0] n_o_cnt;
    logic [CODE_W-1:0]      r_code;
    logic [CODE_W-1:0]      n_code;
    t_status                r_status;
    t_status                n_status;
    logic                   w_ld;

    assign o_ready = !r_valid || i_ready;
    assign w_ld    = i_valid && o_ready;

    always_comb begin
        n_halted = r_halted;
        n_q_cnt  = r_q_cnt;
        n_n_cnt  = r_n_cnt;
        n_o_cnt  = r_o_cnt;
        n_code   = '0;
        n_status = ST_OK;
        if (r_halted) begin
            n_status = ST_HALTED;
        end else if ((i_qres.below || i_qres.above) && !i_clamp_en) begin
            n_status = i_qres.below ? ST_NEG_REJ : ST_OVER_REJ;
            n_halted = 1'b1;
        end else begin
            if (i_qres.below && (r_n_cnt != '1)) begin
                n_n_cnt = r_n_cnt + 1'b1;
            end
            if (i_qres.above && (r_o_cnt != '1)) begin
                n_o_cnt = r_o_cnt + 1'b1;
            end
            if (r_q_cnt != '1) begin
                n_q_cnt = r_q_cnt + 1'b1;
            end
            n_code = i_qres.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_halted <= 1'b0;
            r_q_cnt  <= '0;
            r_n_cnt  <= '0;
            r_o_cnt  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_ld) begin
                r_halted <= n_halted;
                r_q_cnt  <= n_q_cnt;
                r_n_cnt  <= n_n_cnt;
                r_o_cnt  <= n_o_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_code   <= n_code;
            r_status <= n_status;
        end
    end

    assign o_valid           = r_valid;
    assign o_code            = r_code;
    assign o_status          = r_status;
    assign o_quantized_total = total_of(r_q_cnt);
    assign o_negative_total  = total_of(r_n_cnt);
    assign o_overrange_total = total_of(r_o_cnt);

    // once halted only a reset brings the block back
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    // any result other than ok carries a zero code
    a_err_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_status != ST_OK) |-> (r_code == '0))
        else $error("non-zero code on error or halted result");

    // a reported rejection or halt means the halt flag is already set
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_status != ST_OK) |-> r_halted)
        else $error("error result without halt");

    // counters never go backwards
    a_cnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_q_cnt >= $past(r_q_cnt)) && (r_n_cnt >= $past(r_n_cnt))
                 && (r_o_cnt >= $past(r_o_cnt)))
        else $error("counter decreased");

    // a halted block leaves all counters alone
    a_halt_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> $stable(r_q_cnt) && $stable(r_n_cnt) && $stable(r_o_cnt))
        else $error("counter moved while halted");

endmodule

FILE: rtl/linear_sample_quantizer_core.sv
`timescale 1ns / 1ps
// linear sample quantiser: scales signed Q8.24 samples by a gain, clamps or rejects
// out-of-range values and rounds the result to a 16-bit code with running counters.
// input stream s_axis_*: one signed 32-bit sample per request in tdata.
// output stream m_axis_*: one result per sample; tdata carries the code and the
// quantised, negative-clamped and overrange-clamped totals, tuser the status
// (0 ok, 1 negative rejected, 2 overrange rejected, 3 halted by an earlier error).
// config port: i_cfg_we with i_cfg_addr 0 writes linear_gain, 1 writes clamp_enable;
// write only while no samples are in flight.
// throughput: one sample per clock unless m_axis_tready stalls. a result reaches m_axis
// through the input register loaded on acceptance, then the 32x31 multiply register,
// rounding register and counter/status register.
// each stage holds its own request; a stall on m_axis_tready fills the stages one by
// one, so s_axis_tready only drops once all four registers are occupied.
// reset (synchronous, active low) empties the pipeline, clears the counters and the
// halt flag, and sets gain to 1.0 with clamping off.
// with clamping off an out-of-range product halts the block until the next reset.
module linear_sample_quantizer_core
    import lsq_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_addr,
    input  logic [31:0]   i_cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [31:0]   s_axis_tdata,   // [31:0] sample
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [111:0]  m_axis_tdata,   // [15:0] code, [47:16] quantized_total,
                                          // [79:48] negative_total, [111:80] overrange_total
    output logic [1:0]    m_axis_tuser    // [1:0] status
);

    logic [GAIN_W-1:0]  r_gain;
    logic               r_clamp_en;
    logic               w_p_valid;
    logic               w_p_ready;
    t_prod              w_prod;
    logic               w_q_valid;
    logic               w_q_ready;
    t_qres              w_qres;
    logic [CODE_W-1:0]  w_code;
    t_status            w_status;
    logic [TOTAL_W-1:0] w_q_total;
    logic [TOTAL_W-1:0] w_n_total;
    logic [TOTAL_W-1:0] w_o_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= GAIN_RESET;
            r_clamp_en <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_LINEAR_GAIN:  r_gain     <= i_cfg_wdata[GAIN_W-1:0];
                REG_CLAMP_ENABLE: r_clamp_en <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    lsq_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gain   (r_gain),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sample (s_axis_tdata),
        .o_valid  (w_p_valid),
        .i_ready  (w_p_ready),
        .o_prod   (w_prod)
    );

    lsq_quant u_quant (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_p_valid),
        .o_ready (w_p_ready),
        .i_prod  (w_prod),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_qres  (w_qres)
    );

    lsq_acct u_acct (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_clamp_en        (r_clamp_en),
        .i_valid           (w_q_valid),
        .o_ready           (w_q_ready),
        .i_qres            (w_qres),
        .o_valid           (m_axis_tvalid),
        .i_ready           (m_axis_tready),
        .o_code            (w_code),
        .o_status          (w_status),
        .o_quantized_total (w_q_total),
        .o_negative_total  (w_n_total),
        .o_overrange_total (w_o_total)
    );

    assign m_axis_tdata = {w_o_total, w_n_total, w_q_total, w_code};
    assign m_axis_tuser = w_status;

endmodule
